// ----- rtl/core/lpmt_pkg.sv -----
// Shared types and constants for the longest prefix match table.
// No dependencies; imported by every module of the block.
package lpmt_pkg;
   localparam int unsigned V4_BITS = 32;
   localparam int unsigned V6_BITS = 128;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic        is_v6;
      logic [63:0] prefix_high;
      logic [63:0] prefix_low;
      logic [7:0]  prefix_len;
      logic        reject;
   } cmd_type;

   function automatic logic [63:0] mask_high(input logic [7:0] len);
      logic [63:0] m;
      if (len == 8'd0) m = '0;
      else if (len >= 8'd64) m = '1;
      else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> len[5:0]);
      return m;
   endfunction

   function automatic logic [63:0] mask_low(input logic [7:0] len);
      logic [63:0] m;
      logic [7:0]  r;
      r = len - 8'd64;
      if (len <= 8'd64) m = '0;
      else if (len >= 8'd128) m = '1;
      else m = ~(64'hFFFF_FFFF_FFFF_FFFF >> r[5:0]);
      return m;
   endfunction
endpackage

// ----- rtl/core/lpmt_front.sv -----
// Front end: accepts an item, masks the address and checks insert arguments.
// Depends on lpmt_pkg.
module lpmt_front #(
   parameter int PEER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_op,
   input  logic                  req_is_v6,
   input  logic [63:0]           req_address_high,
   input  logic [63:0]           req_address_low,
   input  logic [7:0]            req_prefix_len,
   input  logic [7:0]            req_peer_id,
   output logic                  q_valid,
   output lpmt_pkg::cmd_type     q_cmd,
   output logic [PEER_BITS-1:0]  q_peer,
   input  logic                  q_pop
);
   import lpmt_pkg::*;

   logic                 full_ff, full_in;
   cmd_type              cmd_ff, cmd_in;
   logic [PEER_BITS-1:0] peer_ff, peer_in;

   always_comb begin
      logic [63:0] ah, al;
      logic [7:0]  len;
      ah = req_is_v6 ? req_address_high : {req_address_high[63:32], 32'd0};
      al = req_is_v6 ? req_address_low : 64'd0;
      len = req_prefix_len;
      peer_in = req_peer_id[PEER_BITS-1:0];
      cmd_in.op = op_type'(req_op);
      cmd_in.is_v6 = req_is_v6;
      cmd_in.prefix_len = len;
      cmd_in.reject = 1'b0;
      if (op_type'(req_op) == OP_INSERT) begin
         cmd_in.prefix_high = ah & mask_high(len);
         cmd_in.prefix_low = al & mask_low(len);
         cmd_in.reject = (len > (req_is_v6 ? 8'(V6_BITS) : 8'(V4_BITS)))
                         || (peer_in == '0);
      end else begin
         cmd_in.prefix_high = ah;
         cmd_in.prefix_low = al;
      end
      full_in = full_ff;
      if (q_pop) full_in = 1'b0;
      if (req_valid) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      if (req_valid) begin
         cmd_ff <= cmd_in;
         peer_ff <= peer_in;
      end
   end

   assign q_valid = full_ff;
   assign q_cmd = cmd_ff;
   assign q_peer = peer_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !full_ff || q_pop) else $error("front queue overrun");
endmodule

// ----- rtl/core/lpmt_back.sv -----
// Back end: scans the table one entry a cycle and produces the result.
// Depends on lpmt_pkg.
module lpmt_back #(
   parameter int ENTRIES   = 64,
   parameter int PEER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  lpmt_pkg::cmd_type     q_cmd,
   input  logic [PEER_BITS-1:0]  q_peer,
   output logic                  q_pop,
   output logic                  idle,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic                  rsp_found,
   output logic [7:0]            rsp_match_peer
);
   import lpmt_pkg::*;
   localparam int IW = $clog2(ENTRIES);

   logic [ENTRIES-1:0]   valid_ff;
   logic                 v6_mem [ENTRIES];
   logic [63:0]          ph_mem [ENTRIES];
   logic [63:0]          pl_mem [ENTRIES];
   logic [7:0]           len_mem [ENTRIES];
   logic [PEER_BITS-1:0] peer_mem [ENTRIES];

   back_state_type state_ff, state_in;
   logic [IW:0]    idx_ff, idx_in;
   logic           rd_ok_ff;
   logic [IW-1:0]  rd_idx_ff;
   logic           rd_v6_ff;
   logic [63:0]    rd_ph_ff, rd_pl_ff;
   logic [7:0]     rd_len_ff;
   logic [PEER_BITS-1:0] rd_peer_ff;
   logic           done_ff, done_in, found_ff, found_in, slot_ok_ff, slot_ok_in;
   logic [IW-1:0]  slot_ff, slot_in;
   logic [7:0]     best_ff, best_in;
   logic [PEER_BITS-1:0] mpeer_ff, mpeer_in;
   logic           wr_peer, wr_free, wr_new;
   logic           strobe_in;
   logic [1:0]     status_in;

   always_comb begin
      logic hit, same;
      state_in = state_ff; idx_in = idx_ff;
      done_in = done_ff; found_in = found_ff; slot_ok_in = slot_ok_ff;
      slot_in = slot_ff; best_in = best_ff; mpeer_in = mpeer_ff;
      q_pop = 1'b0; wr_peer = 1'b0; wr_free = 1'b0; wr_new = 1'b0;
      strobe_in = 1'b0; status_in = ST_OK;
      same = rd_v6_ff == q_cmd.is_v6;
      hit = same && ((q_cmd.prefix_high & mask_high(rd_len_ff)) == rd_ph_ff)
                 && ((q_cmd.prefix_low & mask_low(rd_len_ff)) == rd_pl_ff);
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               idx_in = '0; done_in = 1'b0; found_in = 1'b0; slot_ok_in = 1'b0;
               best_in = '0; mpeer_in = '0;
               if (q_cmd.reject || q_cmd.op == OP_CLEAR ||
                   (q_cmd.op == OP_REMOVE && q_peer == '0)) state_in = BK_FINISH;
               else state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (idx_ff < (IW+1)'(ENTRIES)) idx_in = idx_ff + 1'b1;
            if (rd_ok_ff) begin
               if (!valid_ff[rd_idx_ff]) begin
                  if (!slot_ok_in) begin slot_ok_in = 1'b1; slot_in = rd_idx_ff; end
               end else begin
                  case (q_cmd.op)
                     OP_INSERT: if (!done_ff && same && rd_len_ff == q_cmd.prefix_len
                                   && rd_ph_ff == q_cmd.prefix_high
                                   && rd_pl_ff == q_cmd.prefix_low) begin
                        done_in = 1'b1; wr_peer = 1'b1;
                     end
                     OP_LOOKUP: if (hit && (!found_ff || rd_len_ff > best_ff)) begin
                        found_in = 1'b1; best_in = rd_len_ff; mpeer_in = rd_peer_ff;
                     end
                     OP_REMOVE: if (rd_peer_ff == q_peer) wr_free = 1'b1;
                     default: ;
                  endcase
               end
               if (rd_idx_ff == IW'(ENTRIES-1)) state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            q_pop = 1'b1; strobe_in = 1'b1; state_in = BK_IDLE;
            if (q_cmd.op == OP_INSERT) begin
               if (q_cmd.reject) status_in = ST_INVALID;
               else if (!done_ff) begin
                  if (slot_ok_ff) wr_new = 1'b1;
                  else status_in = ST_FULL;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE; valid_ff <= '0; rd_ok_ff <= 1'b0; rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe <= strobe_in;
         rd_ok_ff <= state_ff == BK_SCAN && idx_ff < (IW+1)'(ENTRIES)
                     && state_in == BK_SCAN;
         if (wr_free) valid_ff[rd_idx_ff] <= 1'b0;
         if (wr_new) valid_ff[slot_ff] <= 1'b1;
         if (state_ff == BK_FINISH && q_cmd.op == OP_CLEAR) valid_ff <= '0;
      end
      idx_ff <= idx_in; done_ff <= done_in; found_ff <= found_in;
      slot_ok_ff <= slot_ok_in; slot_ff <= slot_in; best_ff <= best_in;
      mpeer_ff <= mpeer_in;
      rd_idx_ff <= idx_ff[IW-1:0];
      rd_v6_ff <= v6_mem[idx_ff[IW-1:0]];
      rd_ph_ff <= ph_mem[idx_ff[IW-1:0]];
      rd_pl_ff <= pl_mem[idx_ff[IW-1:0]];
      rd_len_ff <= len_mem[idx_ff[IW-1:0]];
      rd_peer_ff <= peer_mem[idx_ff[IW-1:0]];
      if (wr_peer) peer_mem[rd_idx_ff] <= q_peer;
      if (wr_new) begin
         v6_mem[slot_ff] <= q_cmd.is_v6;
         ph_mem[slot_ff] <= q_cmd.prefix_high;
         pl_mem[slot_ff] <= q_cmd.prefix_low;
         len_mem[slot_ff] <= q_cmd.prefix_len;
         peer_mem[slot_ff] <= q_peer;
      end
      if (strobe_in) begin
         rsp_status <= status_in;
         rsp_found <= found_ff;
         rsp_match_peer <= 8'(mpeer_ff);
      end
   end

   assign idle = state_ff == BK_IDLE && !q_valid;

   a_pop_strobe: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_strobe) else $error("pop without result");
   a_found_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_FINISH && found_ff |-> q_cmd.op == OP_LOOKUP)
      else $error("found outside lookup");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(wr_new && (wr_peer || wr_free))) else $error("write clash");
endmodule

// ----- rtl/core/longest_prefix_match_table_core.sv -----
// Top level of the longest prefix match table.
// Depends on lpmt_pkg, lpmt_front and lpmt_back.
//
// Usage: raise start with the req_ fields for one cycle while busy is low;
// that edge accepts the item. Ops: insert, lookup, remove by peer, clear.
// Each item returns one result on rsp_status, rsp_found and rsp_match_peer,
// marked by rsp_strobe for exactly one cycle; the receiver cannot stall.
// Walk: an insert, lookup or remove walks all ENTRIES slots through the
// registered read port of the table memory between accept and strobe; a
// rejected insert, a clear and a remove of peer 0 skip the walk and go
// straight to the finish state. One item is in flight at a time; busy stays
// high until its result strobes. Reset empties the table at once through
// per-slot valid flags; no clearing pass is needed.
module longest_prefix_match_table_core #(
   parameter int ENTRIES   = 64,
   parameter int PEER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic        req_is_v6,
   input  logic [63:0] req_address_high,
   input  logic [63:0] req_address_low,
   input  logic [7:0]  req_prefix_len,
   input  logic [7:0]  req_peer_id,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [7:0]  rsp_match_peer
);
   import lpmt_pkg::*;

   logic                 q_valid, q_pop, idle, take;
   cmd_type              q_cmd;
   logic [PEER_BITS-1:0] q_peer;

   assign take = start && !busy;
   assign busy = !idle;

   lpmt_front #(.PEER_BITS(PEER_BITS)) u_front (
      .clock, .reset, .req_valid(take), .req_op, .req_is_v6, .req_address_high,
      .req_address_low, .req_prefix_len, .req_peer_id,
      .q_valid, .q_cmd, .q_peer, .q_pop);

   lpmt_back #(.ENTRIES(ENTRIES), .PEER_BITS(PEER_BITS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_peer, .q_pop, .idle,
      .rsp_strobe, .rsp_status, .rsp_found, .rsp_match_peer);
endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for the longest prefix match table core.
// Depends on lpmt_pkg and longest_prefix_match_table_core; drives random and
// table-driven commands and checks every result against an internal table model or fixed expected values.
`timescale 1ns / 1ps

module testbench;
   import lpmt_pkg::*;

   localparam int N_SLOTS = 64;

   typedef struct {
      op_type      op;
      logic        is_v6;
      logic [63:0] ah;
      logic [63:0] al;
      logic [7:0]  len;
      logic [7:0]  peer;
      logic        known;
      status_type  st;
      logic        fnd;
      logic [7:0]  mp;
   } cmd_row;

   typedef struct packed {
      status_type  st;
      logic        fnd;
      logic [7:0]  mp;
   } route_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic        req_is_v6 = 1'b0;
   logic [63:0] req_address_high = '0;
   logic [63:0] req_address_low = '0;
   logic [7:0]  req_prefix_len = '0;
   logic [7:0]  req_peer_id = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [7:0]  rsp_match_peer;

   longest_prefix_match_table_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_is_v6(req_is_v6),
      .req_address_high(req_address_high), .req_address_low(req_address_low),
      .req_prefix_len(req_prefix_len), .req_peer_id(req_peer_id),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_found(rsp_found), .rsp_match_peer(rsp_match_peer)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // route table shadow
   logic        rt_valid [N_SLOTS];
   logic        rt_v6    [N_SLOTS];
   logic [63:0] rt_hi    [N_SLOTS];
   logic [63:0] rt_lo    [N_SLOTS];
   logic [7:0]  rt_len   [N_SLOTS];
   logic [7:0]  rt_peer  [N_SLOTS];

   route_result pending_routes[$];
   int          mismatches = 0;
   cmd_row      plan[$];

   function automatic logic [63:0] hi_mask(input int unsigned n);
      if (n == 0) return '0;
      if (n >= 64) return '1;
      return ~(64'hFFFF_FFFF_FFFF_FFFF >> n);
   endfunction

   function automatic logic [63:0] lo_mask(input int unsigned n);
      if (n <= 64) return '0;
      if (n >= 128) return '1;
      return ~(64'hFFFF_FFFF_FFFF_FFFF >> (n - 64));
   endfunction

   function automatic void wipe_routes();
      for (int i = 0; i < N_SLOTS; i++) begin
         rt_valid[i] = 0; rt_v6[i] = 0; rt_hi[i] = '0;
         rt_lo[i] = '0; rt_len[i] = '0; rt_peer[i] = '0;
      end
   endfunction

   function automatic route_result route_apply(input cmd_row c);
      route_result r;
      logic [63:0] ah, al, ph, pl;
      int          free_ix, best;
      bit          hit;
      r = '{ST_OK, 1'b0, 8'd0};
      ah = c.ah; al = c.al;
      if (!c.is_v6) begin
         ah[31:0] = '0; al = '0;
      end
      case (c.op)
         OP_INSERT: begin
            if (c.len > (c.is_v6 ? V6_BITS : V4_BITS) || c.peer == 0) begin
               r.st = ST_INVALID;
            end else begin
               ph = ah & hi_mask(c.len);
               pl = al & lo_mask(c.len);
               hit = 0; free_ix = -1;
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (rt_valid[i]) begin
                     if (!hit && rt_v6[i] == c.is_v6 && rt_len[i] == c.len &&
                         rt_hi[i] == ph && rt_lo[i] == pl) begin
                        rt_peer[i] = c.peer;
                        hit = 1;
                     end
                  end else if (free_ix < 0) begin
                     free_ix = i;
                  end
               end
               if (!hit) begin
                  if (free_ix < 0) begin
                     r.st = ST_FULL;
                  end else begin
                     rt_valid[free_ix] = 1; rt_v6[free_ix] = c.is_v6;
                     rt_hi[free_ix] = ph; rt_lo[free_ix] = pl;
                     rt_len[free_ix] = c.len; rt_peer[free_ix] = c.peer;
                  end
               end
            end
         end
         OP_LOOKUP: begin
            best = -1;
            for (int i = 0; i < N_SLOTS; i++) begin
               if (rt_valid[i] && rt_v6[i] == c.is_v6 &&
                   (ah & hi_mask(rt_len[i])) == rt_hi[i] &&
                   (al & lo_mask(rt_len[i])) == rt_lo[i] && int'(rt_len[i]) > best) begin
                  best = rt_len[i];
                  r.fnd = 1;
                  r.mp = rt_peer[i];
               end
            end
         end
         OP_REMOVE: begin
            if (c.peer != 0) begin
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (rt_valid[i] && rt_peer[i] == c.peer) begin
                     rt_valid[i] = 0; rt_v6[i] = 0; rt_hi[i] = '0;
                     rt_lo[i] = '0; rt_len[i] = '0; rt_peer[i] = '0;
                  end
               end
            end
         end
         default: wipe_routes();
      endcase
      return r;
   endfunction

   function automatic cmd_row mk(input op_type op, input logic v6, input logic [63:0] ah,
                                 input logic [63:0] al, input logic [7:0] len,
                                 input logic [7:0] peer);
      cmd_row c;
      c.op = op; c.is_v6 = v6; c.ah = ah; c.al = al; c.len = len; c.peer = peer;
      c.known = 0; c.st = ST_OK; c.fnd = 0; c.mp = '0;
      return c;
   endfunction

   function automatic cmd_row mk_known(input cmd_row c, input status_type st,
                                       input logic fnd, input logic [7:0] mp);
      c.known = 1; c.st = st; c.fnd = fnd; c.mp = mp;
      return c;
   endfunction

   // few distinct addresses so lookups hit, plus the odd fully random one
   function automatic logic [63:0] pick_addr();
      logic [63:0] a;
      a = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: a[63:48] = 16'hA5C3;
         1: a[63:56] = 8'h0A;
         2: a = {32'hC0A8_0000 | ($urandom & 32'hFF), $urandom};
         default: ;
      endcase
      return a;
   endfunction

   function automatic cmd_row rand_cmd();
      cmd_row c;
      int     k;
      logic   v6;
      logic [7:0] len, peer;
      k = $urandom_range(0, 99);
      v6 = 1'($urandom_range(0, 1));
      peer = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      if ($urandom_range(0, 19) == 0) len = 8'($urandom);
      else len = 8'($urandom_range(0, v6 ? 128 : 32));
      if (k < 45) c = mk(OP_INSERT, v6, pick_addr(), {$urandom, $urandom}, len, peer);
      else if (k < 90) c = mk(OP_LOOKUP, v6, pick_addr(), {$urandom, $urandom}, len, peer);
      else if (k < 98) c = mk(OP_REMOVE, v6, pick_addr(), {$urandom, $urandom}, len, peer);
      else c = mk(OP_CLEAR, v6, pick_addr(), {$urandom, $urandom}, len, peer);
      return c;
   endfunction

   task automatic issue(input cmd_row c);
      route_result r;
      r = route_apply(c);
      if (c.known) r = '{c.st, c.fnd, c.mp};
      req_op <= c.op; req_is_v6 <= c.is_v6;
      req_address_high <= c.ah; req_address_low <= c.al;
      req_prefix_len <= c.len; req_peer_id <= c.peer;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_routes.push_back(r);
      start <= 1'b0;
      // drop start before the next item drives it again
      @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      route_result want;
      if (!reset && rsp_strobe) begin
         if (pending_routes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            want = pending_routes.pop_front();
            if (rsp_status !== want.st || rsp_found !== want.fnd ||
                rsp_match_peer !== want.mp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: status %0d/%0d found %0d/%0d peer %0d/%0d",
                           $realtime, want.st, rsp_status, want.fnd, rsp_found,
                           want.mp, rsp_match_peer);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int burst, wait_cnt;
      wipe_routes();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan.push_back(mk_known(mk(OP_LOOKUP, 1, '1, '1, 8'd0, 8'd0), ST_OK, 0, 8'd0));
      plan.push_back(mk_known(mk(OP_INSERT, 0, '1, '1, 8'd33, 8'd1), ST_INVALID, 0, 8'd0));
      plan.push_back(mk_known(mk(OP_INSERT, 1, '1, '1, 8'd129, 8'd1), ST_INVALID, 0, 8'd0));
      plan.push_back(mk_known(mk(OP_INSERT, 1, '1, '1, 8'd255, 8'd255), ST_INVALID, 0, 8'd0));
      plan.push_back(mk_known(mk(OP_INSERT, 0, '0, '0, 8'd8, 8'd0), ST_INVALID, 0, 8'd0));
      plan.push_back(mk(OP_INSERT, 0, 64'h0A00_0000_FFFF_FFFF, '1, 8'd8, 8'd3));
      plan.push_back(mk(OP_INSERT, 0, 64'h0A01_0000_0000_0000, '0, 8'd16, 8'd4));
      plan.push_back(mk(OP_INSERT, 0, '0, '0, 8'd0, 8'd255));
      plan.push_back(mk(OP_INSERT, 0, '1, '0, 8'd32, 8'd7));
      plan.push_back(mk(OP_LOOKUP, 0, 64'h0A01_0203_1234_5678, '1, 8'd0, 8'd0));
      plan.push_back(mk(OP_LOOKUP, 0, 64'hFFFF_FFFF_0000_0000, '0, 8'd0, 8'd0));
      plan.push_back(mk(OP_LOOKUP, 0, 64'h0B00_0000_0000_0000, '0, 8'd0, 8'd0));
      plan.push_back(mk(OP_INSERT, 1, '1, '1, 8'd128, 8'd9));
      plan.push_back(mk(OP_INSERT, 1, '1, '0, 8'd64, 8'd10));
      plan.push_back(mk(OP_INSERT, 1, '1, '1, 8'd64, 8'd11));
      plan.push_back(mk(OP_INSERT, 1, '0, '0, 8'd0, 8'd12));
      plan.push_back(mk(OP_LOOKUP, 1, '1, '1, 8'd0, 8'd0));
      plan.push_back(mk(OP_LOOKUP, 1, '1, 64'h1, 8'd0, 8'd0));
      plan.push_back(mk(OP_LOOKUP, 1, 64'h0, 64'h5, 8'd0, 8'd0));
      plan.push_back(mk(OP_REMOVE, 0, '0, '0, 8'd0, 8'd0));
      plan.push_back(mk(OP_REMOVE, 0, '0, '0, 8'd0, 8'd11));
      plan.push_back(mk(OP_LOOKUP, 1, '1, 64'h1, 8'd0, 8'd0));
      plan.push_back(mk(OP_CLEAR, 1, '1, '1, 8'd255, 8'd255));
      plan.push_back(mk_known(mk(OP_LOOKUP, 0, '0, '0, 8'd0, 8'd0), ST_OK, 0, 8'd0));
      foreach (plan[i]) issue(plan[i]);

      // fill the table to overflow, with distinct lengths/addresses
      for (int i = 0; i < 66; i++)
         issue(mk(OP_INSERT, 1, 64'(i) << 56, '0, 8'd8 + 8'(i), 8'($urandom_range(1, 255))));
      issue(mk(OP_CLEAR, 0, '0, '0, 8'd0, 8'd0));

      burst = 0;
      for (int n = 0; n < 1400; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            wait_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            repeat (wait_cnt) @(posedge clock);
         end
         burst--;
         if (n == 700) begin
            while (pending_routes.size() != 0) @(posedge clock);
         end
         issue(rand_cmd());
      end

      while (pending_routes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
